/* rtl/stftk_pkg.sv */
// Shared types, widths and codes of the swap-to-front key table.
package stftk_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int KEY_W           = 32;
	localparam int IDX_W           = 4;
	localparam int FILL_W          = 5;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [FILL_W-1:0] fill_t;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic req_load;
		logic cmp_en;
		logic upd_en;
	} ctrl_cmd_t;

endpackage

/* rtl/stftk_if.sv */
// Handshake channels for request words and response words.
interface stftk_req_if;
	logic              valid;
	logic              ready;
	stftk_pkg::op_t    opcode;
	stftk_pkg::key_t   move_key;
	stftk_pkg::idx_t   slot_index;

	modport source (output valid, output opcode, output move_key, output slot_index,
		input ready);
	modport sink (input valid, input opcode, input move_key, input slot_index,
		output ready);
endinterface

interface stftk_rsp_if;
	logic              valid;
	logic              ready;
	logic              hit;
	logic              inserted;
	logic              full_reject;
	stftk_pkg::key_t   read_key;
	logic              read_valid;
	stftk_pkg::fill_t  fill_count;

	modport source (output valid, output hit, output inserted, output full_reject,
		output read_key, output read_valid, output fill_count, input ready);
	modport sink (input valid, input hit, input inserted, input full_reject,
		input read_key, input read_valid, input fill_count, output ready);
endinterface

/* rtl/stftk_ctrl.sv */
// Controller state machine: sequences compare and update, owns both handshakes.
module stftk_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output stftk_pkg::ctrl_cmd_t   cmd
);

	stftk_pkg::state_t state_q;
	stftk_pkg::state_t state_next;
	logic              out_valid_q;
	logic              can_load;
	logic              accept;

	// The result register can take a new word when empty or being drained.
	assign can_load  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			stftk_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			stftk_pkg::ST_CMP: begin
				cmd.cmp_en = 1'b1;
			end
			stftk_pkg::ST_UPD: begin
				in_ready   = can_load;
				cmd.upd_en = can_load;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.req_load = in_valid && in_ready;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			stftk_pkg::ST_IDLE: begin
				if (accept) begin
					state_next = stftk_pkg::ST_CMP;
				end
			end
			stftk_pkg::ST_CMP: begin
				state_next = stftk_pkg::ST_UPD;
			end
			stftk_pkg::ST_UPD: begin
				if (accept) begin
					state_next = stftk_pkg::ST_CMP;
				end else if (can_load) begin
					state_next = stftk_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = stftk_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stftk_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.upd_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/stftk_dp.sv */
// Datapath: key registers, parallel key compare, swap write-back and result register.
module stftk_dp #(
	parameter int TABLE_DEPTH = stftk_pkg::TABLE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stftk_pkg::ctrl_cmd_t   cmd,
	input  stftk_pkg::op_t         opcode,
	input  stftk_pkg::key_t        move_key,
	input  stftk_pkg::idx_t        slot_index,
	output logic                   hit,
	output logic                   inserted,
	output logic                   full_reject,
	output stftk_pkg::key_t        read_key,
	output logic                   read_valid,
	output stftk_pkg::fill_t       fill_count
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int XW = (CW > stftk_pkg::IDX_W) ? CW : stftk_pkg::IDX_W;

	stftk_pkg::key_t   key_store [TABLE_DEPTH];
	logic [CW-1:0]     count_q;

	stftk_pkg::op_t    op_q;
	stftk_pkg::key_t   key_q;
	stftk_pkg::idx_t   idx_q;
	logic              hit_q;
	logic [PW-1:0]     pos_q;

	logic [TABLE_DEPTH-1:0] match;
	logic [PW-1:0]          match_pos;

	logic              wr_en;
	logic [PW-1:0]     wr_addr;
	stftk_pkg::key_t   wr_front;
	stftk_pkg::key_t   wr_back;
	logic [CW-1:0]     count_next;
	logic              res_hit;
	logic              res_ins;
	logic              res_rej;
	stftk_pkg::key_t   res_key;
	logic              res_rvalid;
	logic              is_full;
	logic              idx_in_range;
	logic [PW-1:0]     rd_addr;

	// Only slots below the count take part; live keys are unique, so an OR
	// of the matching indexes gives the hit position.
	always_comb begin
		match_pos = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = (key_store[i] == key_q) && (CW'(i) < count_q);
			if (match[i]) begin
				match_pos = match_pos | PW'(i);
			end
		end
	end

	assign is_full      = (count_q == CW'(TABLE_DEPTH));
	assign idx_in_range = XW'(idx_q) < XW'(count_q);
	assign rd_addr      = PW'(idx_q);

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = pos_q;
		wr_front   = key_store[pos_q];
		wr_back    = key_store[0];
		count_next = count_q;
		res_hit    = 1'b0;
		res_ins    = 1'b0;
		res_rej    = 1'b0;
		res_key    = '0;
		res_rvalid = 1'b0;
		unique case (op_q)
			stftk_pkg::OP_ADD: begin
				if (hit_q) begin
					res_hit = 1'b1;
					wr_en   = 1'b1;
				end else if (is_full) begin
					res_rej = 1'b1;
				end else begin
					// The new key goes to the front, the old front to the end.
					wr_en      = 1'b1;
					wr_addr    = count_q[PW-1:0];
					wr_front   = key_q;
					count_next = count_q + CW'(1);
					res_ins    = 1'b1;
				end
			end
			stftk_pkg::OP_QUERY: begin
				res_hit = hit_q;
			end
			stftk_pkg::OP_CLEAR: begin
				count_next = '0;
			end
			stftk_pkg::OP_READ: begin
				if (idx_in_range) begin
					res_key    = key_store[rd_addr];
					res_rvalid = 1'b1;
				end
			end
			default: begin
				res_hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			op_q  <= opcode;
			key_q <= move_key;
			idx_q <= slot_index;
		end
		if (cmd.cmp_en) begin
			hit_q <= |match;
			pos_q <= match_pos;
		end
		// When the swap partner is slot 0 itself, only the front write applies.
		if (cmd.upd_en && wr_en) begin
			if (wr_addr != '0) begin
				key_store[wr_addr] <= wr_back;
			end
			key_store[0] <= wr_front;
		end
		if (cmd.upd_en) begin
			hit         <= res_hit;
			inserted    <= res_ins;
			full_reject <= res_rej;
			read_key    <= res_key;
			read_valid  <= res_rvalid;
			fill_count  <= stftk_pkg::FILL_W'(count_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.upd_en) begin
			count_q <= count_next;
		end
	end

endmodule

/* rtl/swap_to_front_key_table_unit.sv */
// Top level of the swap-to-front key table: controller plus datapath.
//
//   channel | role   | payload
//   --------+--------+-----------------------------------------------------------
//   req     | sink   | opcode, move_key, slot_index
//   rsp     | source | hit, inserted, full_reject, read_key, read_valid, fill_count
//
// Each word passes a compare state, which matches the key against every live slot,
// and then a write-back state, which writes back the swap and loads the result register.
// A new word is taken in the write-back state, so back-to-back words need no idle
// state between them; a stalled response holds the write-back and with it the request side.
// Reset clears the state machine, the response valid and the fill count; the key
// registers are not reset and are read only below the count.
module swap_to_front_key_table_unit #(
	parameter int TABLE_DEPTH = stftk_pkg::TABLE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	stftk_req_if.sink    req,
	stftk_rsp_if.source  rsp
);

	stftk_pkg::ctrl_cmd_t cmd;

	stftk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	stftk_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (req.opcode),
		.move_key    (req.move_key),
		.slot_index  (req.slot_index),
		.hit         (rsp.hit),
		.inserted    (rsp.inserted),
		.full_reject (rsp.full_reject),
		.read_key    (rsp.read_key),
		.read_valid  (rsp.read_valid),
		.fill_count  (rsp.fill_count)
	);

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the swap-to-front key table with predicted results.
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH      = stftk_pkg::TABLE_DEPTH_DEF;
	localparam int RAND_WORDS = 750;

	typedef struct packed {
		stftk_pkg::op_t  op;
		stftk_pkg::key_t key;
		stftk_pkg::idx_t idx;
	} table_word_t;

	typedef struct packed {
		logic             hit;
		logic             inserted;
		logic             full_reject;
		stftk_pkg::key_t  read_key;
		logic             read_valid;
		stftk_pkg::fill_t fill_count;
	} table_outcome_t;

	logic clk;
	logic arst_n;

	stftk_req_if req_ch ();
	stftk_rsp_if rsp_ch ();

	swap_to_front_key_table_unit #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	table_word_t    pending_words[$];
	table_outcome_t due_outcomes[$];

	// Predicted table contents and fill count.
	stftk_pkg::key_t tbl_keys [DEPTH];
	int              tbl_fill;

	int err_cnt;
	int sent_cnt;
	int got_cnt;
	int gap_left;
	int stall_left;
	int hold_left;
	int holds_done;

	always #10 clk = ~clk;

	// Mostly short gaps, a few long ones, and whole stretches without any.
	function automatic int pick_gap(input int progress);
		int r;
		r = $urandom_range(0, 99);
		if ((progress / 80) % 4 == 2)
			return 0;
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic queue_word(input stftk_pkg::op_t op, input stftk_pkg::key_t key,
		input stftk_pkg::idx_t idx);
		table_word_t w;
		w.op  = op;
		w.key = key;
		w.idx = idx;
		pending_words.push_back(w);
	endtask

	task automatic apply_table_word(input table_word_t w);
		table_outcome_t  o;
		int              pos;
		int              i;
		stftk_pkg::key_t t;
		o   = '0;
		pos = -1;
		if (w.op == stftk_pkg::OP_ADD || w.op == stftk_pkg::OP_QUERY) begin
			for (i = 0; i < tbl_fill; i++) begin
				if (pos < 0 && tbl_keys[i] == w.key)
					pos = i;
			end
		end
		case (w.op)
			stftk_pkg::OP_ADD: begin
				if (pos < 0 && tbl_fill < DEPTH) begin
					tbl_keys[tbl_fill] = w.key;
					pos = tbl_fill;
					tbl_fill++;
					o.inserted = 1'b1;
				end else if (pos < 0) begin
					o.full_reject = 1'b1;
				end else begin
					o.hit = 1'b1;
				end
				// Both a hit and a fresh key end up in slot 0.
				if (pos > 0) begin
					t             = tbl_keys[0];
					tbl_keys[0]   = tbl_keys[pos];
					tbl_keys[pos] = t;
				end
			end
			stftk_pkg::OP_QUERY: begin
				o.hit = (pos >= 0);
			end
			stftk_pkg::OP_CLEAR: begin
				tbl_fill = 0;
			end
			default: begin
				if (int'(w.idx) < tbl_fill) begin
					o.read_key   = tbl_keys[w.idx];
					o.read_valid = 1'b1;
				end
			end
		endcase
		o.fill_count = stftk_pkg::fill_t'(tbl_fill);
		due_outcomes.push_back(o);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endtask

	// Request driver: a word is predicted at the edge where it is accepted.
	always @(posedge clk or negedge arst_n) begin
		table_word_t w;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				w.op  = req_ch.opcode;
				w.key = req_ch.move_key;
				w.idx = req_ch.slot_index;
				apply_table_word(w);
				sent_cnt++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					w = pending_words.pop_front();
					req_ch.opcode     <= w.op;
					req_ch.move_key   <= w.key;
					req_ch.slot_index <= w.idx;
					req_ch.valid      <= 1'b1;
					gap_left = pick_gap(sent_cnt);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response ready: random stalls plus two long hold-offs that back up the request side.
	always @(posedge clk or negedge arst_n) begin
		logic ready_nx;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
			holds_done = 0;
		end else begin
			if (hold_left == 0 && holds_done < 2 && got_cnt >= 120 + 380 * holds_done) begin
				hold_left = 70;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_nx = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				ready_nx = 1'b0;
			end else begin
				ready_nx = 1'b1;
				if ($urandom_range(0, 4) == 0)
					stall_left = pick_gap(got_cnt);
			end
			rsp_ch.ready <= ready_nx;
		end
	end

	// Response monitor.
	always @(posedge clk) begin
		table_outcome_t e;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
			got_cnt++;
			if (due_outcomes.size() == 0) begin
				$error("response word with no request outstanding");
				err_cnt++;
			end else begin
				e = due_outcomes.pop_front();
				check_field("hit", 32'(e.hit), 32'(rsp_ch.hit));
				check_field("inserted", 32'(e.inserted), 32'(rsp_ch.inserted));
				check_field("full_reject", 32'(e.full_reject), 32'(rsp_ch.full_reject));
				check_field("read_key", e.read_key, rsp_ch.read_key);
				check_field("read_valid", 32'(e.read_valid), 32'(rsp_ch.read_valid));
				check_field("fill_count", 32'(e.fill_count), 32'(rsp_ch.fill_count));
			end
		end
	end

	initial begin
		stftk_pkg::key_t key_pool [24];
		int              n;
		int              len;
		int              kind;
		int              r;
		int              i;
		stftk_pkg::idx_t ix;

		clk               = 1'b0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.opcode     = stftk_pkg::OP_ADD;
		req_ch.move_key   = '0;
		req_ch.slot_index = '0;
		rsp_ch.ready      = 1'b0;
		err_cnt           = 0;
		sent_cnt          = 0;
		got_cnt           = 0;
		tbl_fill          = 0;

		// Directed: empty table, extreme keys, hit at the front and further back,
		// filling up, a rejected add on a full table, reads past the count, clear.
		queue_word(stftk_pkg::OP_READ, 32'h0, 4'd15);
		queue_word(stftk_pkg::OP_QUERY, 32'h0, 4'd0);
		queue_word(stftk_pkg::OP_ADD, 32'h0000_0000, 4'd0);
		queue_word(stftk_pkg::OP_ADD, 32'hFFFF_FFFF, 4'd15);
		queue_word(stftk_pkg::OP_ADD, 32'hFFFF_FFFF, 4'd0);
		queue_word(stftk_pkg::OP_ADD, 32'h0000_0000, 4'd0);
		for (i = 0; i < DEPTH - 2; i++)
			queue_word(stftk_pkg::OP_ADD, 32'h5A00_0000 + i * 32'h0101,
				stftk_pkg::idx_t'(i));
		queue_word(stftk_pkg::OP_ADD, 32'h1234_5678, 4'd0);
		queue_word(stftk_pkg::OP_READ, 32'hFFFF_FFFF, 4'd15);
		queue_word(stftk_pkg::OP_QUERY, 32'hFFFF_FFFF, 4'd0);
		queue_word(stftk_pkg::OP_CLEAR, 32'hFFFF_FFFF, 4'd15);
		queue_word(stftk_pkg::OP_READ, 32'h0, 4'd0);

		// Random part: mostly runs on a small key pool so that hits, swaps and
		// full-table rejects are frequent; some refills after clear, some noise.
		for (i = 0; i < 24; i++)
			key_pool[i] = $urandom;
		n = 0;
		while (n < RAND_WORDS) begin
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				queue_word(stftk_pkg::OP_CLEAR, $urandom,
					stftk_pkg::idx_t'($urandom_range(0, 15)));
				len = $urandom_range(DEPTH, DEPTH + 6);
				for (i = 0; i < len; i++)
					queue_word(stftk_pkg::OP_ADD, key_pool[$urandom_range(0, 23)],
						stftk_pkg::idx_t'($urandom_range(0, 15)));
				n += len + 1;
			end else if (kind < 94) begin
				len = $urandom_range(10, 40);
				for (i = 0; i < len; i++) begin
					r  = $urandom_range(0, 99);
					ix = ($urandom_range(0, 1) == 0)
						? stftk_pkg::idx_t'($urandom_range(0, 3))
						: stftk_pkg::idx_t'($urandom_range(0, 15));
					if (r < 8)
						key_pool[$urandom_range(0, 23)] = $urandom;
					if (r < 50)
						queue_word(stftk_pkg::OP_ADD, key_pool[$urandom_range(0, 23)], ix);
					else if (r < 70)
						queue_word(stftk_pkg::OP_QUERY,
							(r < 66) ? key_pool[$urandom_range(0, 23)]
							: stftk_pkg::key_t'($urandom), ix);
					else
						queue_word(stftk_pkg::OP_READ, $urandom, ix);
				end
				n += len;
			end else begin
				len = $urandom_range(3, 10);
				for (i = 0; i < len; i++)
					queue_word(stftk_pkg::op_t'($urandom_range(0, 3)), $urandom,
						stftk_pkg::idx_t'($urandom_range(0, 15)));
				n += len;
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (due_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* swap_to_front_key_table_unit.f */
rtl/stftk_pkg.sv
rtl/stftk_if.sv
rtl/stftk_ctrl.sv
rtl/stftk_dp.sv
rtl/swap_to_front_key_table_unit.sv
dv/tb_top.sv
